[rtl/core/jet_velocity_integrator_macros.svh]
// Assertion macros shared by the jet velocity integrator RTL.
`ifndef JET_VELOCITY_INTEGRATOR_MACROS_SVH
`define JET_VELOCITY_INTEGRATOR_MACROS_SVH
`ifndef SYNTH
// plain property, checked out of reset
`define JVI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// overlapping implication, checked out of reset
`define JVI_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
// next-cycle implication, checked out of reset
`define JVI_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define JVI_ASSERT(lbl, prop, msg)
`define JVI_ASSERT_IMPL(lbl, pre, post, msg)
`define JVI_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/core/jvi_pkg.sv]
// Types and constants of the jet velocity integrator.
`timescale 1ns / 1ps
`default_nettype none
package jvi_pkg;

	// field and register widths
	localparam int VEL_W     = 32;
	localparam int PRES_W    = 32;
	localparam int IMP_W     = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int BGAIN_W   = 24;
	localparam int IGAIN_W   = 32;
	localparam int LIMIT_W   = 32;
	localparam int DENS_W    = 16;

	// register reset values
	localparam logic [BGAIN_W-1:0] BGAIN_RST = 24'd31536;
	localparam logic [IGAIN_W-1:0] IGAIN_RST = 32'd10548921;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 32'd32768000;
	localparam logic [DENS_W-1:0]  DENS_RST  = 16'd39322;

	// fixed point
	localparam int FRAC_SHIFT = 16;
	localparam int GAIN_SHIFT = 24;
	localparam int DIFF_W     = PRES_W + 1;   // pin - pout, or new - old velocity
	localparam int DIFF_D_W   = 49;           // difference term, |d| < 2^48
	localparam int SUM_W      = 50;           // velocity plus increment before saturation
	localparam int IMP_P_W    = 49;           // impulse before clamp

	// digit-serial multiplier
	localparam int MUL_AW    = 48;
	localparam int MUL_BW    = 32;
	localparam int MUL_DIG   = 8;
	localparam int MUL_STEPS = MUL_BW / MUL_DIG;
	localparam int MUL_PW    = MUL_AW + MUL_BW;
	localparam int MUL_SW    = MUL_AW + MUL_DIG;
	localparam int CNT_W     = $clog2(MUL_STEPS + 2);
	localparam logic [CNT_W-1:0] CNT_LOAD = '0;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS + 1);

	// saturation bounds at the sum width
	localparam logic signed [SUM_W-1:0] VEL_MAX =
		{{(SUM_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] VEL_MIN =
		{{(SUM_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BERNOULLI_GAIN,
		REG_IMPULSE_GAIN,
		REG_IMPULSE_LIMIT,
		REG_HALF_AIR_DENSITY
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_V,
		ST_HD_V,
		ST_GN_V,
		ST_SQ_S,
		ST_HD_S,
		ST_GN_S,
		ST_IMP,
		ST_WB
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic capture;
		logic wb;
	} ctrl_t;

endpackage
`default_nettype wire

[rtl/core/jet_velocity_integrator.sv]
// Jet velocity integrator: Euler step of the unsteady Bernoulli equation per sample.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one sample per transaction:
//    pressure_inside and pressure_outside, signed Q16.16.
//  - Output channel (out_valid/out_ready) carries one result per sample:
//    jet_velocity, steady_velocity (signed Q16.16, saturating) and impulse_out.
//  - Config port: cfg_we writes cfg_data into register cfg_index
//    (0 bernoulli gain, 1 impulse gain, 2 impulse limit, 3 half air density).
//    Write only while no sample is in flight.
//  - One shared 48 x 8 digit multiplier does all seven products in sequence:
//    |v|^2, *density, *gain for each velocity, then change * impulse gain.
//    Each product runs load, 4 digit steps, then capture.
//  - in_ready is high only when idle, also while a result waits on out_ready.
//  - A stalled receiver holds the block in write-back; velocities are
//    committed only when the new result enters the output register.
//  - Reset clears both velocities, loads register defaults, empties output.
`timescale 1ns / 1ps
`default_nettype none
`include "jet_velocity_integrator_macros.svh"
module jet_velocity_integrator
	import jvi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [PRES_W-1:0] pressure_inside,
	input  logic signed [PRES_W-1:0] pressure_outside,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VEL_W-1:0]  jet_velocity,
	output logic signed [VEL_W-1:0]  steady_velocity,
	output logic [IMP_W-1:0]         impulse_out
);

	// config registers
	logic [BGAIN_W-1:0] bgain_q;
	logic [IGAIN_W-1:0] igain_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [DENS_W-1:0]  dens_q;

	// control
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	ctrl_t            ctrl;
	logic             is_mul;

	// state and per-sample working registers
	logic signed [VEL_W-1:0]    v_q, s_q, nv_q, ns_q;
	logic signed [PRES_W-1:0]   pin_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic [MUL_AW-1:0]          sq_q;
	logic signed [DIFF_D_W-1:0] d_q;
	logic [IMP_W-1:0]           imp_q;

	// multiplier
	logic [MUL_AW-1:0] a_q;
	logic [MUL_PW-1:0] pr_q;
	logic [MUL_SW-1:0] psum;
	logic [MUL_AW-1:0] op_a;
	logic [MUL_BW-1:0] op_b;

	// output register
	logic                    out_valid_q;
	logic signed [VEL_W-1:0] jv_q, sv_q;
	logic [IMP_W-1:0]        io_q;

	// operand and capture logic
	logic [VEL_W-1:0]           v_mag, s_mag;
	logic [DIFF_D_W-1:0]        d_abs;
	logic signed [DIFF_W-1:0]   chg;
	logic [MUL_AW-1:0]          chg_mag;
	logic [MUL_AW-1:0]          prod_frac;
	logic [MUL_AW-1:0]          prod_gain;
	logic signed [DIFF_D_W-1:0] diff_sel, d_next;
	logic signed [SUM_W-1:0]    old_ext, r_ext, vsum, vsat;
	logic [IMP_P_W-1:0]         imp_p;
	logic [IMP_W-1:0]           imp_next;

	//------------------------------------------------------------------
	// config writes
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bgain_q <= BGAIN_RST;
			igain_q <= IGAIN_RST;
			limit_q <= LIMIT_RST;
			dens_q  <= DENS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BERNOULLI_GAIN:   bgain_q <= cfg_data[BGAIN_W-1:0];
				REG_IMPULSE_GAIN:     igain_q <= cfg_data[IGAIN_W-1:0];
				REG_IMPULSE_LIMIT:    limit_q <= cfg_data[LIMIT_W-1:0];
				REG_HALF_AIR_DENSITY: dens_q  <= cfg_data[DENS_W-1:0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// sequencer: next state
	//------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SQ_V;
			ST_SQ_V: if (cnt_q == CNT_LAST) state_d = ST_HD_V;
			ST_HD_V: if (cnt_q == CNT_LAST) state_d = ST_GN_V;
			ST_GN_V: if (cnt_q == CNT_LAST) state_d = ST_SQ_S;
			ST_SQ_S: if (cnt_q == CNT_LAST) state_d = ST_HD_S;
			ST_HD_S: if (cnt_q == CNT_LAST) state_d = ST_GN_S;
			ST_GN_S: if (cnt_q == CNT_LAST) state_d = ST_IMP;
			ST_IMP:  if (cnt_q == CNT_LAST) state_d = ST_WB;
			ST_WB:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	//------------------------------------------------------------------
	// sequencer: strobes
	//------------------------------------------------------------------
	always_comb begin
		is_mul       = state_q inside {ST_SQ_V, ST_HD_V, ST_GN_V, ST_SQ_S, ST_HD_S,
		                               ST_GN_S, ST_IMP};
		ctrl.accept  = (state_q == ST_IDLE) && in_valid;
		ctrl.load    = is_mul && (cnt_q == CNT_LOAD);
		ctrl.capture = is_mul && (cnt_q == CNT_LAST);
		ctrl.step    = is_mul && !ctrl.load && !ctrl.capture;
		ctrl.wb      = (state_q == ST_WB) && (!out_valid_q || out_ready);
		in_ready     = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= CNT_LOAD;
		end else begin
			state_q <= state_d;
			if (ctrl.capture)
				cnt_q <= CNT_LOAD;
			else if (ctrl.load || ctrl.step)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	//------------------------------------------------------------------
	// operand select at load
	//------------------------------------------------------------------
	always_comb begin
		v_mag   = v_q[VEL_W-1] ? (~$unsigned(v_q) + VEL_W'(1)) : $unsigned(v_q);
		s_mag   = s_q[VEL_W-1] ? (~$unsigned(s_q) + VEL_W'(1)) : $unsigned(s_q);
		d_abs   = d_q[DIFF_D_W-1] ? (~$unsigned(d_q) + DIFF_D_W'(1)) : $unsigned(d_q);
		chg     = DIFF_W'(nv_q) - DIFF_W'(v_q);
		// only a rising velocity gives an impulse
		chg_mag = (!chg[DIFF_W-1] && (chg != '0)) ? MUL_AW'(chg[DIFF_W-2:0]) : '0;
		case (state_q)
			ST_SQ_V: begin
				op_a = MUL_AW'(v_mag);
				op_b = MUL_BW'(v_mag);
			end
			ST_SQ_S: begin
				op_a = MUL_AW'(s_mag);
				op_b = MUL_BW'(s_mag);
			end
			ST_HD_V, ST_HD_S: begin
				op_a = sq_q;
				op_b = MUL_BW'(dens_q);
			end
			ST_GN_V, ST_GN_S: begin
				op_a = d_abs[MUL_AW-1:0];
				op_b = MUL_BW'(bgain_q);
			end
			ST_IMP: begin
				op_a = chg_mag;
				op_b = MUL_BW'(igain_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	//------------------------------------------------------------------
	// digit-serial multiplier, multiplier digits consumed LSB first;
	// low product bits shift into the vacated multiplier field
	//------------------------------------------------------------------
	assign psum = MUL_SW'(pr_q[MUL_PW-1:MUL_BW]) + MUL_SW'(a_q) * MUL_SW'(pr_q[MUL_DIG-1:0]);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q  <= op_a;
			pr_q <= MUL_PW'(op_b);
		end else if (ctrl.step) begin
			pr_q <= {psum, pr_q[MUL_BW-1:MUL_DIG]};
		end
	end

	//------------------------------------------------------------------
	// product post-processing
	//------------------------------------------------------------------
	always_comb begin
		prod_frac = pr_q[FRAC_SHIFT +: MUL_AW];
		prod_gain = pr_q[GAIN_SHIFT +: MUL_AW];
		// driven uses pin - pout, steady uses pin alone
		diff_sel  = (state_q == ST_HD_V) ? DIFF_D_W'(diff_q) : DIFF_D_W'(pin_q);
		d_next    = diff_sel - $signed(DIFF_D_W'(prod_frac));
		old_ext   = (state_q == ST_GN_V) ? SUM_W'(v_q) : SUM_W'(s_q);
		r_ext     = $signed(SUM_W'(prod_gain));
		// increment truncates toward zero: apply sign after the gain
		vsum      = d_q[DIFF_D_W-1] ? (old_ext - r_ext) : (old_ext + r_ext);
		if (vsum > VEL_MAX)
			vsat = VEL_MAX;
		else if (vsum < VEL_MIN)
			vsat = VEL_MIN;
		else
			vsat = vsum;
		imp_p    = pr_q[FRAC_SHIFT +: IMP_P_W];
		imp_next = (imp_p > IMP_P_W'(limit_q)) ? limit_q : imp_p[IMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			pin_q  <= pressure_inside;
			diff_q <= DIFF_W'(pressure_inside) - DIFF_W'(pressure_outside);
		end
		if (ctrl.capture) begin
			case (state_q)
				ST_SQ_V, ST_SQ_S: sq_q  <= prod_frac;
				ST_HD_V, ST_HD_S: d_q   <= d_next;
				ST_GN_V:          nv_q  <= vsat[VEL_W-1:0];
				ST_GN_S:          ns_q  <= vsat[VEL_W-1:0];
				ST_IMP:           imp_q <= imp_next;
				default: ;
			endcase
		end
		if (ctrl.wb) begin
			jv_q <= nv_q;
			sv_q <= ns_q;
			io_q <= imp_q;
		end
	end

	//------------------------------------------------------------------
	// velocity state and output valid
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			s_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.wb) begin
				v_q         <= nv_q;
				s_q         <= ns_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign jet_velocity    = jv_q;
	assign steady_velocity = sv_q;
	assign impulse_out     = io_q;

	//------------------------------------------------------------------
	// checks
	//------------------------------------------------------------------
	`JVI_ASSERT_NEXT(a_start, ctrl.accept, state_q == ST_SQ_V && cnt_q == CNT_LOAD, "no start")
	`JVI_ASSERT_NEXT(a_state_hold, state_q != ST_WB, $stable(v_q) && $stable(s_q), "state moved")
	`JVI_ASSERT_IMPL(a_cnt_idle, !is_mul, cnt_q == CNT_LOAD, "digit counter busy")
	`JVI_ASSERT_IMPL(a_valid_wb, $rose(out_valid_q), $past(state_q) == ST_WB, "no write-back")

endmodule
`default_nettype wire

[dv/jet_velocity_integrator_test.sv]
// Self-checking testbench of the jet velocity integrator: predicted samples vs. DUT results.
`timescale 1ns / 1ps
module jet_velocity_integrator_test;
	import jvi_pkg::*;

	// One expected output transaction.
	typedef struct packed {
		logic [VEL_W-1:0] jet;
		logic [VEL_W-1:0] steady;
		logic [IMP_W-1:0] impulse;
	} jet_result_t;

	localparam logic signed [PRES_W-1:0] P_MAX = 32'sh7FFFFFFF;
	localparam logic signed [PRES_W-1:0] P_MIN = 32'sh80000000;
	localparam logic [CFG_W-1:0] ALL_ONES = 32'hFFFFFFFF;

	// DUT inputs, all known from time zero; reset asserted from the start
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [PRES_W-1:0] pressure_inside = '0;
	logic signed [PRES_W-1:0] pressure_outside = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [VEL_W-1:0]  jet_velocity;
	logic signed [VEL_W-1:0]  steady_velocity;
	logic [IMP_W-1:0]         impulse_out;

	// Predictor copy of the registers and the two velocities
	logic [BGAIN_W-1:0]      gain_reg = BGAIN_RST;
	logic [IGAIN_W-1:0]      impulse_gain_reg = IGAIN_RST;
	logic [LIMIT_W-1:0]      impulse_limit_reg = LIMIT_RST;
	logic [DENS_W-1:0]       density_reg = DENS_RST;
	logic signed [VEL_W-1:0] jet_state = '0;
	logic signed [VEL_W-1:0] steady_state = '0;

	jet_result_t pending_results[$];

	// Burst stretches: neither side idles while this is set
	logic burst = 1'b0;
	int   stall_left = 0;
	int   failures = 0;
	int   samples_sent = 0;
	int   results_checked = 0;
	int   reg_writes = 0;

	jet_velocity_integrator uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pressure_inside  (pressure_inside),
		.pressure_outside (pressure_outside),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.jet_velocity     (jet_velocity),
		.steady_velocity  (steady_velocity),
		.impulse_out      (impulse_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// half density times velocity squared, Q16.16, truncated twice
	function automatic logic signed [63:0] drag_term(input logic signed [VEL_W-1:0] vel);
		logic [VEL_W-1:0] mag;
		logic [63:0]      sq;
		logic [63:0]      prod;
		mag = vel[VEL_W-1] ? (~vel + 1'b1) : vel;
		sq = ({32'd0, mag} * {32'd0, mag}) >> FRAC_SHIFT;
		prod = (sq * {48'd0, density_reg}) >> FRAC_SHIFT;
		return $signed(prod);
	endfunction

	// gain times difference, magnitude truncated so the result rounds toward zero
	function automatic logic signed [63:0] gained_increment(input logic signed [63:0] d);
		logic [63:0]        mag;
		logic [95:0]        prod;
		logic signed [63:0] r;
		mag = d[63] ? (~d + 64'd1) : d;
		prod = {32'd0, mag} * {72'd0, gain_reg};
		r = $signed(prod[87:24]);
		return d[63] ? -r : r;
	endfunction

	function automatic logic signed [VEL_W-1:0] saturate_velocity(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[VEL_W-1:0];
	endfunction

	// Only a rise of the driven velocity produces an impulse
	function automatic logic [IMP_W-1:0] impulse_of_rise(input logic signed [63:0] change);
		logic [95:0] prod;
		logic [79:0] r;
		if (change <= 0)
			return '0;
		prod = {32'd0, change} * {64'd0, impulse_gain_reg};
		r = prod[95:16];
		if (r > {48'd0, impulse_limit_reg})
			return impulse_limit_reg;
		return r[IMP_W-1:0];
	endfunction

	// One Euler step of both velocities; updates the predictor state
	function automatic jet_result_t bernoulli_step(input logic signed [PRES_W-1:0] pin,
			input logic signed [PRES_W-1:0] pout);
		logic signed [63:0]      p_in;
		logic signed [63:0]      p_out;
		logic signed [63:0]      old_jet;
		logic signed [63:0]      old_steady;
		logic signed [63:0]      new_jet_wide;
		logic signed [VEL_W-1:0] new_jet;
		logic signed [VEL_W-1:0] new_steady;
		jet_result_t             res;
		p_in = pin;
		p_out = pout;
		old_jet = jet_state;
		old_steady = steady_state;
		new_jet = saturate_velocity(old_jet + gained_increment((p_in - p_out)
			- drag_term(jet_state)));
		new_steady = saturate_velocity(old_steady + gained_increment(p_in
			- drag_term(steady_state)));
		new_jet_wide = new_jet;
		res.jet = new_jet;
		res.steady = new_steady;
		res.impulse = impulse_of_rise(new_jet_wide - old_jet);
		jet_state = new_jet;
		steady_state = new_steady;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Drive one sample; valid holds with a stable payload until accepted
	task automatic send_sample(input logic signed [PRES_W-1:0] pin,
			input logic signed [PRES_W-1:0] pout);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pressure_inside <= pin;
		pressure_outside <= pout;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(bernoulli_step(pin, pout));
		samples_sent++;
	endtask

	// Stop sending and wait until every predicted result has come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all four registers on back-to-back cycles; block must be idle
	task automatic configure(input logic [CFG_W-1:0] bgain, input logic [CFG_W-1:0] igain,
			input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] dens);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_BERNOULLI_GAIN;
		cfg_data <= bgain;
		gain_reg = bgain[BGAIN_W-1:0];
		@(negedge clk);
		cfg_index <= REG_IMPULSE_GAIN;
		cfg_data <= igain;
		impulse_gain_reg = igain[IGAIN_W-1:0];
		@(negedge clk);
		cfg_index <= REG_IMPULSE_LIMIT;
		cfg_data <= limit;
		impulse_limit_reg = limit[LIMIT_W-1:0];
		@(negedge clk);
		cfg_index <= REG_HALF_AIR_DENSITY;
		cfg_data <= dens;
		density_reg = dens[DENS_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes += 4;
	endtask

	// Audio-sized pressures half the time, with full-range words and range ends mixed in
	function automatic logic signed [PRES_W-1:0] random_pressure();
		logic signed [PRES_W-1:0] v;
		case ($urandom_range(0, 3))
			0, 1: begin
				v = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
			end
			2: begin
				v = $urandom();
			end
			default: begin
				case ($urandom_range(0, 4))
					0: v = P_MAX;
					1: v = P_MIN;
					2: v = '0;
					3: v = -1;
					default: v = 32'sh00010000;
				endcase
			end
		endcase
		return v;
	endfunction

	// Register value: zero, all ones (upper bits dropped by narrow registers),
	// the reset value, or a random word
	function automatic logic [CFG_W-1:0] random_reg(input logic [CFG_W-1:0] rst);
		logic [CFG_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = '0;
			1: v = ALL_ONES;
			2: v = rst;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Output side: random back-pressure and the result checker
	// ------------------------------------------------------------------

	// Stall only once a result is waiting, so gaps hit the output register
	always @(negedge clk) begin
		if (out_valid && stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		jet_result_t want;
		if (out_valid && out_ready) begin
			stall_left <= burst ? 0 : $urandom_range(0, 4);
			if (pending_results.size() == 0) begin
				$error("output transaction with no result pending");
				failures++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (jet_velocity !== want.jet) begin
					$error("jet_velocity: expected %0d, actual %0d",
						$signed(want.jet), jet_velocity);
					failures++;
				end
				if (steady_velocity !== want.steady) begin
					$error("steady_velocity: expected %0d, actual %0d",
						$signed(want.steady), steady_velocity);
					failures++;
				end
				if (impulse_out !== want.impulse) begin
					$error("impulse_out: expected %0d, actual %0d",
						want.impulse, impulse_out);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values: zero, range ends, reverse flow
	task automatic test_reset_defaults();
		send_sample('0, '0);
		send_sample(P_MAX, '0);
		send_sample(P_MAX, P_MIN);
		send_sample(P_MIN, P_MAX);
		send_sample(32'sh00010000, 32'sh00020000);
		send_sample(-1, '0);
	endtask

	// Unit gain and no drag: one step hits either end of the velocity range
	task automatic test_velocity_saturation();
		wait_idle();
		configure(ALL_ONES, IGAIN_RST, ALL_ONES, '0);
		send_sample(P_MAX, P_MIN);
		send_sample(P_MAX, P_MIN);
		send_sample(P_MIN, P_MAX);
		send_sample(P_MIN, P_MAX);
	endtask

	// Impulse clamp, zero and negative change, then a zero limit
	task automatic test_impulse_clamp();
		wait_idle();
		configure(ALL_ONES, ALL_ONES, 32'h00010000, '0);
		send_sample(32'sh40000000, '0);
		send_sample(32'sh00020000, '0);
		send_sample('0, '0);
		send_sample('0, 32'sh00010000);
		wait_idle();
		configure(ALL_ONES, IGAIN_RST, '0, '0);
		send_sample(32'sh00100000, '0);
	endtask

	// Full drag with a large velocity, zero impulse gain, then zero gain
	task automatic test_drag_and_gain_extremes();
		wait_idle();
		configure(ALL_ONES, '0, ALL_ONES, ALL_ONES);
		send_sample(P_MAX, P_MIN);
		send_sample('0, '0);
		send_sample('0, '0);
		wait_idle();
		configure('0, IGAIN_RST, LIMIT_RST, DENS_RST);
		send_sample(P_MAX, '0);
		send_sample(P_MIN, '0);
	endtask

	// Random register settings per phase, random samples, burst stretches,
	// and a full drain halfway through each phase
	task automatic test_random_phases();
		int phase;
		int i;
		for (phase = 0; phase < 5; phase++) begin
			wait_idle();
			configure(random_reg({8'd0, BGAIN_RST}), random_reg(IGAIN_RST),
				random_reg(LIMIT_RST), random_reg({16'd0, DENS_RST}));
			for (i = 0; i < 150; i++) begin
				burst = (i % 60) < 12;
				if (i == 75)
					wait_idle();
				send_sample(random_pressure(), random_pressure());
			end
			burst = 1'b0;
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_reset_defaults();
		test_velocity_saturation();
		test_impulse_clamp();
		test_drag_and_gain_extremes();
		test_random_phases();
		wait_idle();
		// nothing more is expected; give a stray result time to show up
		repeat (60) @(negedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			failures++;
		end
		$display("Sent %0d samples under default, saturating, clamping and random settings",
			samples_sent);
		$display("Compared %0d results field by field after %0d register writes",
			results_checked, reg_writes);
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
